// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

	// default heap geometry
	localparam int HeapGranules = 4096;
	localparam int HeaderBytes  = 40;

	// field widths
	localparam int CMD_W  = 2;
	localparam int SIZE_W = 17;
	localparam int OFF_W  = 16;
	localparam int ST_W   = 3;
	localparam int USED_W = 17;

	// word widths, packed and padded to bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_NULL    = 3'd1;
	localparam logic [ST_W-1:0] ST_NOFIT   = 3'd2;
	localparam logic [ST_W-1:0] ST_INVALID = 3'd3;
	localparam logic [ST_W-1:0] ST_DOUBLE  = 3'd4;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// one command at a time; ready only in idle, which is entered again when the result is registered
// allocate: blocks are read and checked in order; a fit is split and relinked if large enough, then marked
// free: the header is read and checked, then the block merges with free next and previous blocks
// reallocate: header check, then allocate and free as above; result held until taken
// after reset a clearing pass writes every granule before the first word is taken
module first_fit_heap_allocator #(
	parameter int HEAP_GRANULES = ffha_pkg::HeapGranules,
	parameter int HEADER_BYTES  = ffha_pkg::HeaderBytes
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// command, request_bytes, payload_offset, zero pad
	input  logic [ffha_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// status, result_offset, payload_bytes, used_bytes, zero pad
	output logic [ffha_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import ffha_pkg::*;

	localparam int GW = (HEAP_GRANULES > 1) ? $clog2(HEAP_GRANULES) : 1;
	localparam int LW = $clog2(HEAP_GRANULES + 1);
	localparam int NW = 14;
	localparam int SPLIT_MIN = (HEADER_BYTES + 16 + 15) / 16;

	typedef struct packed {
		logic          mark;
		logic          used;
		logic [LW-1:0] len;
		logic [GW-1:0] prev;
	} word_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LOC_RD, S_LOC_CHK, S_AL_RD, S_AL_CHK, S_AL_SPLIT,
		S_AL_G_W, S_NN_RD, S_NN_W, S_REL_RD, S_REL_G, S_REL_N_RD, S_REL_N_CHK,
		S_REL_G_W, S_REL_P_RD, S_REL_P_CHK, S_REL_GM_W, S_FIN
	} state_t;

	word_t mem [HEAP_GRANULES];
	word_t rdata_q;

	state_t state_q, ret_q;
	logic [GW-1:0]     clr_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [SIZE_W-1:0] size_q;
	logic [OFF_W-1:0]  off_q;
	logic [NW-1:0]     need_q;
	logic [GW-1:0]     tg_q;
	logic [LW-1:0]     wg_q;
	logic [LW-1:0]     x_q;
	logic [LW-1:0]     y_q;
	logic [GW-1:0]     z_q;
	word_t             cur_q;
	logic              re_q;
	logic [ST_W-1:0]   st_q;
	logic [OFF_W-1:0]  res_q;
	logic [SIZE_W-1:0] pay_q;
	logic [USED_W-1:0] used_q;
	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	// input word fields
	logic [CMD_W-1:0]  in_cmd;
	logic [SIZE_W-1:0] in_size;
	logic [OFF_W-1:0]  in_off;
	assign in_cmd  = s_axis_tdata[1:0];
	assign in_size = s_axis_tdata[18:2];
	assign in_off  = s_axis_tdata[34:19];

	// precheck of the payload offset
	logic [OFF_W-1:0] in_d;
	logic [11:0]      in_dg;
	logic             in_bad;
	logic [17:0]      in_sum;
	always_comb begin
		in_d   = in_off - OFF_W'(HEADER_BYTES);
		in_dg  = in_d[15:4];
		in_bad = (32'(in_off) < HEADER_BYTES) || (in_d[3:0] != 4'd0)
			|| (32'(in_dg) >= HEAP_GRANULES);
		in_sum = 18'(in_size) + 18'(HEADER_BYTES) + 18'd15;
	end

	// walk and merge arithmetic on the read word
	word_t            rd;
	logic             al_fit;
	logic [LW-1:0]    al_rest;
	logic [LW:0]      al_next;
	logic [LW:0]      al_n;
	logic [LW-1:0]    mg_len;
	logic [LW:0]      mg_end;
	logic [LW-1:0]    pm_len;
	logic [LW:0]      pm_end;
	logic [31:0]      rd_bytes;
	always_comb begin
		rd       = rdata_q;
		al_fit   = !rd.used && (32'(rd.len) >= 32'(need_q));
		al_rest  = rd.len - LW'(need_q);
		al_next  = {1'b0, wg_q} + {1'b0, rd.len};
		al_n     = {1'b0, wg_q} + (LW+1)'(need_q);
		mg_len   = cur_q.len + rd.len;
		mg_end   = (LW+1)'(tg_q) + {1'b0, mg_len};
		pm_len   = rd.len + cur_q.len;
		pm_end   = (LW+1)'(cur_q.prev) + {1'b0, pm_len};
		rd_bytes = 32'({rd.len, 4'b0000});
	end

	// memory addressing per state
	logic          we;
	logic [GW-1:0] wa;
	word_t         wd;
	logic [GW-1:0] ra;
	always_comb begin
		we = 1'b0;
		wa = tg_q;
		wd = cur_q;
		ra = tg_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '{mark: (clr_q == '0), used: 1'b0,
					len: LW'(HEAP_GRANULES), prev: '0};
			end
			S_AL_RD:    ra = wg_q[GW-1:0];
			S_NN_RD:    ra = y_q[GW-1:0];
			S_REL_N_RD: ra = x_q[GW-1:0];
			S_REL_P_RD: ra = cur_q.prev;
			S_AL_SPLIT: begin
				we = 1'b1;
				wa = x_q[GW-1:0];
				wd = '{mark: 1'b1, used: 1'b0, len: cur_q.len - LW'(need_q),
					prev: wg_q[GW-1:0]};
			end
			S_NN_W: begin
				we = 1'b1;
				wa = y_q[GW-1:0];
				wd = rd;
				wd.prev = z_q;
			end
			S_AL_G_W: begin
				we = 1'b1;
				wa = wg_q[GW-1:0];
				wd = cur_q;
				wd.mark = 1'b1;
				wd.used = 1'b1;
			end
			S_REL_N_CHK: begin
				we = !rd.used;
				wa = x_q[GW-1:0];
				wd = rd;
				wd.mark = 1'b0;
			end
			S_REL_G_W: begin
				we = 1'b1;
				wa = tg_q;
				wd = cur_q;
			end
			S_REL_P_CHK: begin
				we = !rd.used;
				wa = cur_q.prev;
				wd = rd;
				wd.len = pm_len;
			end
			S_REL_GM_W: begin
				we = 1'b1;
				wa = tg_q;
				wd = cur_q;
				wd.mark = 1'b0;
			end
			default: ;
		endcase
	end

	// block table
	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rdata_q <= mem[ra];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ret_q     <= S_FIN;
			clr_q     <= '0;
			used_q    <= '0;
			m_valid_q <= 1'b0;
			re_q      <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == HEAP_GRANULES - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q  <= in_cmd;
						size_q <= in_size;
						off_q  <= in_off;
						need_q <= NW'(in_sum >> 4);
						tg_q   <= GW'(in_dg);
						wg_q   <= '0;
						re_q   <= 1'b0;
						st_q   <= ST_OK;
						res_q  <= '0;
						pay_q  <= '0;
						if (in_cmd == CMD_ALLOC || (in_cmd == CMD_REALLOC && in_off == '0)) begin
							if (in_size == '0) begin
								st_q    <= ST_NULL;
								state_q <= S_FIN;
							end else
								state_q <= S_AL_RD;
						end else if (in_off == '0) begin
							state_q <= S_FIN;
						end else if (in_bad) begin
							st_q    <= ST_INVALID;
							state_q <= S_FIN;
						end else
							state_q <= S_LOC_RD;
					end
				end
				S_LOC_RD: state_q <= S_LOC_CHK;
				S_LOC_CHK: begin
					state_q <= S_FIN;
					if (!rd.mark)
						st_q <= ST_INVALID;
					else if (cmd_q == CMD_QUERY)
						pay_q <= SIZE_W'(rd_bytes - 32'(HEADER_BYTES));
					else if (!rd.used)
						st_q <= ST_DOUBLE;
					else if (cmd_q == CMD_FREE)
						state_q <= S_REL_RD;
					else if (size_q == '0) begin
						st_q    <= ST_NULL;
						state_q <= S_REL_RD;
					end else if (rd_bytes >= 32'(size_q) + 32'(HEADER_BYTES))
						res_q <= off_q;
					else begin
						re_q    <= 1'b1;
						state_q <= S_AL_RD;
					end
				end
				// first-fit walk
				S_AL_RD: state_q <= S_AL_CHK;
				S_AL_CHK: begin
					if (al_fit) begin
						cur_q <= rd;
						x_q   <= al_n[LW-1:0];
						y_q   <= al_next[LW-1:0];
						z_q   <= al_n[GW-1:0];
						if (32'(al_rest) >= SPLIT_MIN)
							state_q <= S_AL_SPLIT;
						else
							state_q <= S_AL_G_W;
					end else if (32'(al_next) >= HEAP_GRANULES) begin
						st_q    <= ST_NOFIT;
						state_q <= S_FIN;
					end else begin
						wg_q    <= al_next[LW-1:0];
						state_q <= S_AL_RD;
					end
				end
				S_AL_SPLIT: begin
					cur_q.len <= LW'(need_q);
					ret_q     <= S_AL_G_W;
					if (32'(y_q) < HEAP_GRANULES)
						state_q <= S_NN_RD;
					else
						state_q <= S_AL_G_W;
				end
				S_AL_G_W: begin
					used_q <= used_q + USED_W'({cur_q.len, 4'b0000});
					res_q  <= OFF_W'(32'(wg_q) * 16 + HEADER_BYTES);
					st_q   <= ST_OK;
					if (re_q)
						state_q <= S_REL_RD;
					else
						state_q <= S_FIN;
				end
				// back link of the block after a changed one
				S_NN_RD: state_q <= S_NN_W;
				S_NN_W:  state_q <= ret_q;
				// release of the block at tg
				S_REL_RD: state_q <= S_REL_G;
				S_REL_G: begin
					cur_q  <= '{mark: rd.mark, used: 1'b0, len: rd.len, prev: rd.prev};
					used_q <= used_q - USED_W'(rd_bytes);
					x_q    <= LW'((LW+1)'(tg_q) + {1'b0, rd.len});
					if (32'(tg_q) + 32'(rd.len) < HEAP_GRANULES)
						state_q <= S_REL_N_RD;
					else
						state_q <= S_REL_G_W;
				end
				S_REL_N_RD: state_q <= S_REL_N_CHK;
				S_REL_N_CHK: begin
					state_q <= S_REL_G_W;
					if (!rd.used) begin
						cur_q.len <= mg_len;
						y_q       <= mg_end[LW-1:0];
						z_q       <= tg_q;
						ret_q     <= S_REL_G_W;
						if (32'(mg_end) < HEAP_GRANULES)
							state_q <= S_NN_RD;
					end
				end
				S_REL_G_W: begin
					if (tg_q != '0)
						state_q <= S_REL_P_RD;
					else
						state_q <= S_FIN;
				end
				S_REL_P_RD: state_q <= S_REL_P_CHK;
				S_REL_P_CHK: begin
					if (!rd.used) begin
						y_q     <= pm_end[LW-1:0];
						z_q     <= cur_q.prev;
						state_q <= S_REL_GM_W;
					end else
						state_q <= S_FIN;
				end
				S_REL_GM_W: begin
					ret_q <= S_FIN;
					if (32'(y_q) < HEAP_GRANULES)
						state_q <= S_NN_RD;
					else
						state_q <= S_FIN;
				end
				// result word out
				S_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= OUT_DATA_W'({used_q, pay_q, res_q, st_q});
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
